/* rtl/sptq_pkg.sv */
// Shared constants and types of the strict priority task queue.
package sptq_pkg;

  localparam int NUM_PRIORITIES = 4;
  localparam int QUEUE_DEPTH    = 16;
  localparam int HANDLE_WIDTH   = 32;

  // Fixed widths of the channel fields.
  localparam int HANDLE_FIELD_W = 32;
  localparam int PRIO_FIELD_W   = 2;

  localparam int LVL_W  = $clog2(NUM_PRIORITIES);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = LVL_W + PTR_W;
  localparam int STORE_DEPTH = 2 ** ADDR_W;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  // Controller to datapath.
  typedef struct packed {
    logic enq;          // append the input handle (datapath drops it when full)
    logic deq;          // pop the selected level and start the store read
    logic res_ram;      // result comes from the store read data
    logic res_to_out;   // load the result into the output register
    logic res_to_skid;  // park the result in the skid register
    logic skid_to_out;  // move the parked result forward
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_deq;  // current input beat asks for a dequeue
    logic hit;     // at least one level holds a handle
  } status_t;

  typedef struct packed {
    logic                      found;
    logic [HANDLE_FIELD_W-1:0] handle;
    logic [PRIO_FIELD_W-1:0]   prio;
    logic                      overflow;
  } res_t;

endpackage

/* rtl/sptq_if.sv */
// Valid/ready channel interfaces for request and result beats.
interface sptq_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  priority_req;
  logic [31:0] task_handle;

  modport source (output valid, output mode, output priority_req, output task_handle,
                  input ready);
  modport sink (input valid, input mode, input priority_req, input task_handle,
                output ready);
endinterface

interface sptq_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] out_handle;
  logic [1:0]  out_priority;
  logic        overflow;

  modport source (output valid, output found, output out_handle, output out_priority,
                  output overflow, input ready);
  modport sink (input valid, input found, input out_handle, input out_priority,
                input overflow, output ready);
endinterface

/* rtl/sptq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sptq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sptq_ctrl.sv */
// Controller: item sequencing and output/skid occupancy.
module sptq_ctrl import sptq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e state_d, state_q;
  logic   out_v_d, out_v_q;
  logic   skid_v_d, skid_v_q;
  logic   accept, out_take, go_read, produce;
  cmd_t   cmd;

  assign in_ready_o = (state_q == ST_IDLE) && !skid_v_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_take   = out_v_q && out_ready_i;
  assign go_read    = accept && status_i.is_deq && status_i.hit;
  assign produce    = (accept && !go_read) || (state_q == ST_READ);

  always_comb begin
    cmd             = '0;
    cmd.enq         = accept && !status_i.is_deq;
    cmd.deq         = go_read;
    cmd.res_ram     = (state_q == ST_READ);
    cmd.res_to_out  = produce && !skid_v_q && (!out_v_q || out_take);
    cmd.res_to_skid = produce && !cmd.res_to_out;
    cmd.skid_to_out = out_take && skid_v_q;
  end

  always_comb begin
    state_d  = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go_read) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    out_v_d  = (out_v_q && !out_take) || cmd.res_to_out || cmd.skid_to_out;
    skid_v_d = (skid_v_q && !cmd.skid_to_out) || cmd.res_to_skid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign cmd_o       = cmd;

  // Never overwrite a parked result.
  a_skid_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_to_skid |-> !skid_v_q)
    else $error("skid register overwritten");

  // A parked result always has an occupied output register ahead of it.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a result while the output register is empty");

  // Every dequeue that found a handle moves on to the read state.
  a_read_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.deq |=> (state_q == ST_READ) && cmd.res_ram)
    else $error("store read not followed by its result");

endmodule

/* rtl/sptq_dp.sv */
// Datapath: per-level pointers and counts, handle store, result registers.
module sptq_dp import sptq_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      mode_i,
  input  logic [1:0]                priority_req_i,
  input  logic [HANDLE_FIELD_W-1:0] task_handle_i,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  output res_t                      res_o
);

  logic [PTR_W-1:0] head_q [NUM_PRIORITIES];
  logic [PTR_W-1:0] tail_q [NUM_PRIORITIES];
  logic [CNT_W-1:0] cnt_q  [NUM_PRIORITIES];
  logic [NUM_PRIORITIES-1:0] full, nonempty;

  logic [LVL_W-1:0]        lvl, sel, prio_q;
  logic                    do_enq, do_deq;
  logic [HANDLE_WIDTH-1:0] rdata;
  res_t                    res, out_q, skid_q;

  // Saturate the requested level to the top level.
  always_comb begin
    if (int'(priority_req_i) > NUM_PRIORITIES - 1) begin
      lvl = LVL_W'(NUM_PRIORITIES - 1);
    end else begin
      lvl = LVL_W'(priority_req_i);
    end
  end

  // Highest non-empty level wins.
  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_PRIORITIES; i++) begin
      full[i]     = (cnt_q[i] == CNT_W'(QUEUE_DEPTH));
      nonempty[i] = (cnt_q[i] != '0);
      if (nonempty[i]) begin
        sel = LVL_W'(i);
      end
    end
  end

  assign do_enq = cmd_i.enq && !full[lvl];
  assign do_deq = cmd_i.deq;

  assign status_o.is_deq = (mode_i == MODE_DEQ);
  assign status_o.hit    = |nonempty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (do_enq) begin
        tail_q[lvl] <= (tail_q[lvl] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q[lvl] + 1'b1;
        cnt_q[lvl]  <= cnt_q[lvl] + 1'b1;
      end
      if (do_deq) begin
        head_q[sel] <= (head_q[sel] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q[sel] + 1'b1;
        cnt_q[sel]  <= cnt_q[sel] - 1'b1;
      end
    end
  end

  sptq_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_enq),
    .waddr_i ({lvl, tail_q[lvl]}),
    .wdata_i (HANDLE_WIDTH'(task_handle_i)),
    .re_i    (do_deq),
    .raddr_i ({sel, head_q[sel]}),
    .rdata_o (rdata)
  );

  always_comb begin
    res = '0;
    if (cmd_i.res_ram) begin
      res.found  = 1'b1;
      res.handle = HANDLE_FIELD_W'(rdata);
      res.prio   = PRIO_FIELD_W'(prio_q);
    end else begin
      res.overflow = (mode_i == MODE_ENQ) && full[lvl];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_deq) begin
      prio_q <= sel;
    end
    if (cmd_i.skid_to_out) begin
      out_q <= skid_q;
    end else if (cmd_i.res_to_out) begin
      out_q <= res;
    end
    if (cmd_i.res_to_skid) begin
      skid_q <= res;
    end
  end

  assign res_o = out_q;

endmodule

/* rtl/strict_priority_task_queue.sv */
// Strict priority task queue top level: one handle FIFO per priority level.
// An enqueue or a dequeue of an empty queue set gives its result via the output
// register; a dequeue that finds a handle first passes the registered read port of
// the handle store. Throughput: one item per cycle while the skid register is empty;
// a successful dequeue holds off the next beat until its store read completes.
// Reset (asynchronous, active low) empties every level at once; no clearing pass.
module strict_priority_task_queue import sptq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sptq_in_if.sink    req_i,
  sptq_out_if.source res_o
);

  // Command and status between the sequencer and the datapath.
  cmd_t    cmd;
  status_t status;
  res_t    res;

  // Controller: accept beats, hold a dequeue while the store read completes,
  // and steer each result into the output register or the skid register so
  // that a new beat can be taken while a result waits downstream.
  sptq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: saturate the level, pick the highest non-empty level with a
  // priority encoder, advance pointers and counts, and drop a full enqueue
  // with overflow flagged.
  sptq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (req_i.mode),
    .priority_req_i (req_i.priority_req),
    .task_handle_i  (req_i.task_handle),
    .cmd_i          (cmd),
    .status_o       (status),
    .res_o          (res)
  );

  // Drive the result beat from the output register.
  assign res_o.found        = res.found;
  assign res_o.out_handle   = res.handle;
  assign res_o.out_priority = res.prio;
  assign res_o.overflow     = res.overflow;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the strict priority task queue.
module tb;
  import sptq_pkg::*;

  // One request beat as the sender sees it.
  typedef struct {
    mode_e                     mode;
    logic [PRIO_FIELD_W-1:0]   prio;
    logic [HANDLE_FIELD_W-1:0] handle;
  } job_t;

  // Handle bits the block keeps; the rest of the field is dropped on enqueue.
  localparam int KEPT_W = (HANDLE_WIDTH < HANDLE_FIELD_W) ? HANDLE_WIDTH : HANDLE_FIELD_W;
  localparam logic [HANDLE_FIELD_W-1:0] HANDLE_MASK =
    {HANDLE_FIELD_W{1'b1}} >> (HANDLE_FIELD_W - KEPT_W);

  localparam int N_JOBS       = 1300;
  localparam int CALM_TAIL    = 150;   // last beats are sent and taken without idling
  localparam int HOLD_AT      = 400;   // result count at which the long hold-off starts
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 3000;  // cycles with no beat on either side
  localparam int MAX_REPORTS  = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  sptq_in_if  req_if ();
  sptq_out_if res_if ();

  strict_priority_task_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  job_t job_feed [$];     // beats still to be offered
  res_t due_results [$];  // results owed by the block, oldest first
  int   fault_count  = 0;
  int   results_seen = 0;

  // Shadow copy of the per-level FIFOs.
  logic [HANDLE_FIELD_W-1:0] slots [NUM_PRIORITIES][QUEUE_DEPTH];
  int lvl_head [NUM_PRIORITIES] = '{default: 0};
  int lvl_tail [NUM_PRIORITIES] = '{default: 0};
  int lvl_fill [NUM_PRIORITIES] = '{default: 0};

  // Apply one accepted beat to the shadow FIFOs and record the result it owes.
  task automatic shadow_queue_step(input job_t j);
    res_t r;
    int   lvl;
    int   p;
    r = '0;
    if (j.mode == MODE_ENQ) begin
      // Saturate out-of-range levels to the top level.
      lvl = (int'(j.prio) > NUM_PRIORITIES - 1) ? NUM_PRIORITIES - 1 : int'(j.prio);
      if (lvl_fill[lvl] >= QUEUE_DEPTH) begin
        r.overflow = 1'b1;  // full: drop the handle, leave state alone
      end else begin
        slots[lvl][lvl_tail[lvl]] = j.handle & HANDLE_MASK;
        lvl_tail[lvl] = (lvl_tail[lvl] + 1 >= QUEUE_DEPTH) ? 0 : lvl_tail[lvl] + 1;
        lvl_fill[lvl]++;
      end
    end else begin
      // Serve the highest non-empty level; nothing found leaves an all-zero result.
      for (p = NUM_PRIORITIES - 1; p >= 0; p--) begin
        if (!r.found && lvl_fill[p] != 0) begin
          r.found  = 1'b1;
          r.handle = slots[p][lvl_head[p]];
          r.prio   = PRIO_FIELD_W'(p);
          lvl_head[p] = (lvl_head[p] + 1 >= QUEUE_DEPTH) ? 0 : lvl_head[p] + 1;
          lvl_fill[p]--;
        end
      end
    end
    due_results.insert(due_results.size(), r);
  endtask

  function automatic job_t mk_job(input mode_e m, input int p,
                                  input logic [HANDLE_FIELD_W-1:0] h);
    job_t j;
    j.mode   = m;
    j.prio   = PRIO_FIELD_W'(p);
    j.handle = h;
    return j;
  endfunction

  // Append one beat to the feed.
  task automatic add_job(input job_t j);
    job_feed.insert(job_feed.size(), j);
  endtask

  // Handles: mostly random, sometimes the extremes.
  function automatic logic [HANDLE_FIELD_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Driver: offer beats from job_feed, hold while stalled, idle in bursts.
  // ------------------------------------------------------------------
  job_t on_wire;     // beat currently presented on the request channel
  int   send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.mode         <= MODE_ENQ;
      req_if.priority_req <= '0;
      req_if.task_handle  <= '0;
      send_gap = 0;
    end else begin
      // Book the beat the block takes at this edge before choosing the next one.
      if (req_if.valid && req_if.ready) shadow_queue_step(on_wire);
      // Hold a stalled beat unchanged; otherwise pick idle or the next beat.
      if (!(req_if.valid && !req_if.ready)) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (job_feed.size() > 0) begin
          if (job_feed.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(0, 14);  // this cycle is the first idle one
          end else begin
            on_wire   = job_feed[0];
            job_feed.delete(0);
            nxt_valid = 1'b1;
          end
        end
        req_if.valid <= nxt_valid;
        if (nxt_valid) begin
          req_if.mode         <= on_wire.mode;
          req_if.priority_req <= on_wire.prio;
          req_if.task_handle  <= on_wire.handle;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: take result beats, compare with the oldest owed result.
  // The receiver also stalls in bursts and holds off once for a long stretch
  // so that the block backs up and drops ready on the request side.
  // ------------------------------------------------------------------
  int   take_gap  = 0;
  int   hold_left = 0;
  logic held_once = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    logic nxt_ready;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      take_gap  = 0;
      hold_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("result beat with nothing owed: found=%0b handle=%h prio=%0d ovf=%0b",
                     res_if.found, res_if.out_handle, res_if.out_priority, res_if.overflow);
        end else begin
          exp_r = due_results[0];
          due_results.delete(0);
          if (res_if.found !== exp_r.found || res_if.out_handle !== exp_r.handle ||
              res_if.out_priority !== exp_r.prio || res_if.overflow !== exp_r.overflow) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("mismatch at result %0d: exp found=%0b handle=%h prio=%0d ovf=%0b",
                       results_seen, exp_r.found, exp_r.handle, exp_r.prio, exp_r.overflow);
              $display("  got found=%0b handle=%h prio=%0d ovf=%0b",
                       res_if.found, res_if.out_handle, res_if.out_priority, res_if.overflow);
            end
          end
        end
      end
      nxt_ready = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held_once && results_seen >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
      end else if (take_gap > 0) begin
        take_gap--;
      end else if (job_feed.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
        take_gap = $urandom_range(0, 14);
      end else begin
        nxt_ready = 1'b1;
      end
      res_if.ready <= nxt_ready;
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  int stuck_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni && !(req_if.valid && req_if.ready) && !(res_if.valid && res_if.ready)) begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[strict_priority_task_queue] ERROR");
        $finish;
      end
    end else begin
      stuck_cycles = 0;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus and end of run.
  // ------------------------------------------------------------------
  initial begin
    int   n;
    int   run_len;
    int   enq_pct;
    int   focus;
    int   k;
    rst_ni = 1'b0;

    // Directed: dequeue with everything empty (ignored fields all ones).
    add_job(mk_job(MODE_DEQ, 3, '1));
    // One handle per level, zero and all-ones handles among them.
    add_job(mk_job(MODE_ENQ, 0, '0));
    add_job(mk_job(MODE_ENQ, 3, '1));
    add_job(mk_job(MODE_ENQ, 1, 32'h5A5A_A5A5));
    add_job(mk_job(MODE_ENQ, 2, 32'h8000_0001));
    // Drain in strict priority order; the zero handle must come back found.
    for (k = 0; k < 4; k++) add_job(mk_job(MODE_DEQ, 0, '0));
    // Fill one level to the brim and push once more to overflow it.
    for (k = 0; k <= QUEUE_DEPTH; k++) add_job(mk_job(MODE_ENQ, 1, $urandom));
    n = job_feed.size();

    // Random: runs that lean towards filling, draining or balance, some of
    // them aimed at one level so that overflow and pointer wrap come often.
    while (n < N_JOBS) begin
      run_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      focus = ($urandom_range(0, 1) == 0) ? $urandom_range(0, NUM_PRIORITIES - 1) : -1;
      for (k = 0; k < run_len && n < N_JOBS; k++) begin
        if ($urandom_range(1, 100) <= enq_pct)
          add_job(mk_job(MODE_ENQ,
            (focus >= 0 && $urandom_range(0, 3) != 0) ? focus : $urandom_range(0, 3),
            pick_handle()));
        else
          add_job(mk_job(MODE_DEQ, $urandom_range(0, 3), $urandom));
        n++;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to go in and every owed result to come out.
    while (job_feed.size() != 0 || req_if.valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0 && due_results.size() == 0) begin
      $display("[strict_priority_task_queue] OK");
    end else begin
      $display("[strict_priority_task_queue] ERROR");
    end
    $finish;
  end

endmodule
